// ===== design/lav_pkg.sv =====
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NORM_W = 32;            // normalized magnitude width, max < 2^31
  localparam int DIV_W = NORM_W + FRAC_BITS + 1;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic signed [63:0] c0;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
  } vec64_t;

  typedef struct packed {
    q_t c0;
    q_t c1;
    q_t c2;
  } vec32_t;

  typedef struct packed {
    q_t ex;
    q_t ey;
    q_t ez;
    q_t ux;
    q_t uy;
    q_t uz;
  } ctx_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Position of the highest set bit, 0 when v is zero.
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    msb64 = p;
  endfunction

endpackage

// ===== design/lav_norm.sv =====
// Normalize a three-component vector. Fully pipelined: scale, square and sum,
// a bit-per-stage square root, then a bit-per-stage divider for each lane.
module lav_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  lav_pkg::vec64_t   in_vec,
  input  lav_pkg::ctx_t     in_ctx,
  input  lav_pkg::vec32_t   in_aux,
  output logic              out_vld,
  output lav_pkg::vec32_t   out_vec,
  output lav_pkg::ctx_t     out_ctx,
  output lav_pkg::vec32_t   out_aux
);

  localparam int SQ = 32;                 // root iterations (sum < 2^64)
  localparam int DV = lav_pkg::DIV_W;     // quotient bits

  typedef struct packed {
    logic              vld;
    logic [2:0]        neg;
    logic              zero;
    logic [30:0]       m0;
    logic [30:0]       m1;
    logic [30:0]       m2;
    lav_pkg::ctx_t     ctx;
    lav_pkg::vec32_t   aux;
  } hdr_t;

  // stage 1: magnitudes and shift amount
  hdr_t        s1_r;
  logic [63:0] a0_r, a1_r, a2_r;
  logic [5:0]  sh_r;
  logic [63:0] a0, a1, a2, mx;

  always_comb begin
    a0 = lav_pkg::mag64(in_vec.c0);
    a1 = lav_pkg::mag64(in_vec.c1);
    a2 = lav_pkg::mag64(in_vec.c2);
    mx = a0 | a1 | a2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= in_vld;
    end
    s1_r.neg  <= {in_vec.c2[63], in_vec.c1[63], in_vec.c0[63]};
    s1_r.zero <= (mx == 64'd0);
    s1_r.m0   <= '0;
    s1_r.m1   <= '0;
    s1_r.m2   <= '0;
    s1_r.ctx  <= in_ctx;
    s1_r.aux  <= in_aux;
    a0_r <= a0;
    a1_r <= a1;
    a2_r <= a2;
    sh_r <= lav_pkg::msb64(mx);
  end

  // stage 2: align so the largest lies in [2^30, 2^31)
  hdr_t s2_r;
  logic [63:0] b0, b1, b2;

  always_comb begin
    if (sh_r >= 6'd30) begin
      b0 = a0_r >> (sh_r - 6'd30);
      b1 = a1_r >> (sh_r - 6'd30);
      b2 = a2_r >> (sh_r - 6'd30);
    end else begin
      b0 = a0_r << (6'd30 - sh_r);
      b1 = a1_r << (6'd30 - sh_r);
      b2 = a2_r << (6'd30 - sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else begin
      s2_r.vld <= s1_r.vld;
    end
    s2_r.neg  <= s1_r.neg;
    s2_r.zero <= s1_r.zero;
    s2_r.m0   <= b0[30:0];
    s2_r.m1   <= b1[30:0];
    s2_r.m2   <= b2[30:0];
    s2_r.ctx  <= s1_r.ctx;
    s2_r.aux  <= s1_r.aux;
  end

  // stage 3: sum of squares
  hdr_t        s3_r;
  logic [63:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
    end else begin
      s3_r.vld <= s2_r.vld;
    end
    s3_r.neg  <= s2_r.neg;
    s3_r.zero <= s2_r.zero;
    s3_r.m0   <= s2_r.m0;
    s3_r.m1   <= s2_r.m1;
    s3_r.m2   <= s2_r.m2;
    s3_r.ctx  <= s2_r.ctx;
    s3_r.aux  <= s2_r.aux;
    sum_r <= 64'(s2_r.m0) * 64'(s2_r.m0) + 64'(s2_r.m1) * 64'(s2_r.m1)
           + 64'(s2_r.m2) * 64'(s2_r.m2);
  end

  // square root: one result bit per stage
  hdr_t        rh_r   [SQ];
  logic [63:0] rrem_r [SQ];
  logic [31:0] rroot_r[SQ];
  logic [63:0] rsrc_r [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    hdr_t        h_in;
    logic [63:0] rem_in, src_in, rem_sh, trial;
    logic [31:0] root_in;
    if (k == 0) begin : g_head
      assign h_in    = s3_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = sum_r;
    end else begin : g_body
      assign h_in    = rh_r[k-1];
      assign rem_in  = rrem_r[k-1];
      assign root_in = rroot_r[k-1];
      assign src_in  = rsrc_r[k-1];
    end
    always_comb begin
      rem_sh = {rem_in[61:0], src_in[63:62]};
      trial  = {30'd0, root_in, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rh_r[k].vld <= 1'b0;
      end else begin
        rh_r[k].vld <= h_in.vld;
      end
      rh_r[k].neg  <= h_in.neg;
      rh_r[k].zero <= h_in.zero;
      rh_r[k].m0   <= h_in.m0;
      rh_r[k].m1   <= h_in.m1;
      rh_r[k].m2   <= h_in.m2;
      rh_r[k].ctx  <= h_in.ctx;
      rh_r[k].aux  <= h_in.aux;
      rsrc_r[k] <= {src_in[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rrem_r[k]  <= rem_sh - trial;
        rroot_r[k] <= {root_in[30:0], 1'b1};
      end else begin
        rrem_r[k]  <= rem_sh;
        rroot_r[k] <= {root_in[30:0], 1'b0};
      end
    end
  end

  // restoring divider, three lanes, one quotient bit per stage
  localparam int NW = 31 + lav_pkg::FRAC_BITS + 32;
  hdr_t        dh_r  [DV];
  logic [31:0] dlen_r[DV];
  logic [NW-1:0] dn_r [3][DV];
  logic [DV-1:0] dq_r [3][DV];
  logic [32:0]   dr_r [3][DV];

  for (genvar k = 0; k < DV; k++) begin : g_div
    hdr_t        h_in;
    logic [31:0] len_in;
    if (k == 0) begin : g_head
      assign h_in   = rh_r[SQ-1];
      assign len_in = rroot_r[SQ-1];
    end else begin : g_body
      assign h_in   = dh_r[k-1];
      assign len_in = dlen_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dh_r[k].vld <= 1'b0;
      end else begin
        dh_r[k].vld <= h_in.vld;
      end
      dh_r[k].neg  <= h_in.neg;
      dh_r[k].zero <= h_in.zero;
      dh_r[k].m0   <= h_in.m0;
      dh_r[k].m1   <= h_in.m1;
      dh_r[k].m2   <= h_in.m2;
      dh_r[k].ctx  <= h_in.ctx;
      dh_r[k].aux  <= h_in.aux;
      dlen_r[k] <= len_in;
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NW-1:0] n_in;
      logic [DV-1:0] q_in;
      logic [32:0]   r_in, r_sh;
      if (k == 0) begin : g_head
        logic [30:0]   m;
        logic [NW-1:0] num;
        assign m = (l == 0) ? h_in.m0 : (l == 1) ? h_in.m1 : h_in.m2;
        // numerator m * 2^F + floor(L/2), left aligned in the shifter
        assign num  = NW'({m, {lav_pkg::FRAC_BITS{1'b0}}}) + NW'(len_in >> 1);
        assign n_in = num << (NW - DV);
        assign q_in = '0;
        assign r_in = '0;
      end else begin : g_body
        assign n_in = dn_r[l][k-1];
        assign q_in = dq_r[l][k-1];
        assign r_in = dr_r[l][k-1];
      end
      assign r_sh = {r_in[31:0], n_in[NW-1]};
      always_ff @(posedge clk) begin
        dn_r[l][k] <= {n_in[NW-2:0], 1'b0};
        if (r_sh >= {1'b0, len_in}) begin
          dr_r[l][k] <= r_sh - {1'b0, len_in};
          dq_r[l][k] <= {q_in[DV-2:0], 1'b1};
        end else begin
          dr_r[l][k] <= r_sh;
          dq_r[l][k] <= {q_in[DV-2:0], 1'b0};
        end
      end
    end
  end

  // sign and zero handling
  hdr_t ht;
  logic [31:0] q0, q1, q2;

  always_comb begin
    ht = dh_r[DV-1];
    q0 = ht.zero ? 32'd0 : dq_r[0][DV-1][31:0];
    q1 = ht.zero ? 32'd0 : dq_r[1][DV-1][31:0];
    q2 = ht.zero ? 32'd0 : dq_r[2][DV-1][31:0];
    out_vld = ht.vld;
    out_vec.c0 = ht.neg[0] ? -q0 : q0;
    out_vec.c1 = ht.neg[1] ? -q1 : q1;
    out_vec.c2 = ht.neg[2] ? -q2 : q2;
    out_ctx = ht.ctx;
    out_aux = ht.aux;
  end

endmodule

// ===== design/lav_cross.sv =====
// Registered exact cross product a x b of 32-bit signed vectors.
module lav_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  lav_pkg::vec32_t in_a,
  input  lav_pkg::vec32_t in_b,
  input  lav_pkg::ctx_t   in_ctx,
  input  lav_pkg::vec32_t in_aux,
  output logic            out_vld,
  output lav_pkg::vec64_t out_vec,
  output lav_pkg::ctx_t   out_ctx,
  output lav_pkg::vec32_t out_aux
);

  logic signed [63:0] p_r [6];
  logic               v1_r;
  lav_pkg::ctx_t      c1_r;
  lav_pkg::vec32_t    x1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1_r    <= in_vld;
      out_vld <= v1_r;
    end
    p_r[0] <= 64'(in_a.c1) * 64'(in_b.c2);
    p_r[1] <= 64'(in_a.c2) * 64'(in_b.c1);
    p_r[2] <= 64'(in_a.c2) * 64'(in_b.c0);
    p_r[3] <= 64'(in_a.c0) * 64'(in_b.c2);
    p_r[4] <= 64'(in_a.c0) * 64'(in_b.c1);
    p_r[5] <= 64'(in_a.c1) * 64'(in_b.c0);
    c1_r <= in_ctx;
    x1_r <= in_aux;
    out_vec.c0 <= p_r[0] - p_r[1];
    out_vec.c1 <= p_r[2] - p_r[3];
    out_vec.c2 <= p_r[4] - p_r[5];
    out_ctx <= c1_r;
    out_aux <= x1_r;
  end

endmodule

// ===== design/lav_trans.sv =====
// Translation -(axis . eye), rounded half away from zero, saturated.
module lav_trans (
  input  logic            clk,
  input  lav_pkg::vec32_t in_axis,
  input  lav_pkg::ctx_t   in_ctx,
  output lav_pkg::q_t     out_t
);

  logic signed [63:0] p_r [3];
  logic signed [65:0] d_r;
  logic [65:0]        m, q;

  always_ff @(posedge clk) begin
    p_r[0] <= 64'(in_axis.c0) * 64'(in_ctx.ex);
    p_r[1] <= 64'(in_axis.c1) * 64'(in_ctx.ey);
    p_r[2] <= 64'(in_axis.c2) * 64'(in_ctx.ez);
    d_r <= -(66'(p_r[0]) + 66'(p_r[1]) + 66'(p_r[2]));
  end

  always_comb begin
    m = d_r[65] ? 66'(-d_r) : 66'(d_r);
    q = (m + (66'd1 << (lav_pkg::FRAC_BITS - 1))) >> lav_pkg::FRAC_BITS;
    if (d_r[65]) begin
      out_t = (q > 66'h80000000) ? 32'sh80000000 : 32'(-q);
    end else begin
      out_t = (q > 66'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
    end
  end

endmodule

// ===== design/look_at_view_matrix_unit.sv =====
// Right-handed look-at matrix in signed Q16.16. Pulse start with eye, target
// and up while busy is low; four rows follow on out_valid in consecutive
// cycles, row 0 first, last_row on row 3. The path runs through the eye -
// target register, three chained normalizers (each a bit-per-stage square
// root and divider), two registered cross products, the translation
// registers and the row serializer. After an accepted item busy stays high
// until the gap counter gap_r runs down; start is not taken while busy is
// high. The receiver cannot stall; rows must be taken as they appear.
module look_at_view_matrix_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_eye_x,
  input  logic [31:0] in_eye_y,
  input  logic [31:0] in_eye_z,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_up_x,
  input  logic [31:0] in_up_y,
  input  logic [31:0] in_up_z,
  output logic        out_valid,
  output logic [1:0]  out_row_index,
  output logic [31:0] out_col0,
  output logic [31:0] out_col1,
  output logic [31:0] out_col2,
  output logic [31:0] out_col3,
  output logic        out_last_row
);

  logic [1:0] gap_r;
  logic       acc;
  assign busy = (gap_r != 2'd0);
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (acc) begin
      gap_r <= 2'd3;
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // stage 0: eye - target
  logic            v0_r;
  lav_pkg::vec64_t d_r;
  lav_pkg::ctx_t   c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= acc;
    end
    d_r.c0 <= 64'($signed(in_eye_x)) - 64'($signed(in_target_x));
    d_r.c1 <= 64'($signed(in_eye_y)) - 64'($signed(in_target_y));
    d_r.c2 <= 64'($signed(in_eye_z)) - 64'($signed(in_target_z));
    c0_r <= {in_eye_x, in_eye_y, in_eye_z, in_up_x, in_up_y, in_up_z};
  end

  logic            zv, xcv, xv, ycv, yv;
  lav_pkg::vec32_t z, zc_aux, x, xz, y, yz, zy;
  lav_pkg::vec64_t xc, yc;
  lav_pkg::ctx_t   zctx, xcctx, xctx, xzctx, ycctx, yctx;
  lav_pkg::vec32_t up_v, nul, xzx, yx;

  assign nul = '0;

  lav_norm u_nz (.clk, .rst_n, .in_vld(v0_r), .in_vec(d_r), .in_ctx(c0_r),
    .in_aux(nul), .out_vld(zv), .out_vec(z), .out_ctx(zctx), .out_aux(zc_aux));

  assign up_v = {zctx.ux, zctx.uy, zctx.uz};

  lav_cross u_cx (.clk, .rst_n, .in_vld(zv), .in_a(up_v), .in_b(z),
    .in_ctx(zctx), .in_aux(z), .out_vld(xcv), .out_vec(xc), .out_ctx(xcctx),
    .out_aux(xz));

  lav_norm u_nx (.clk, .rst_n, .in_vld(xcv), .in_vec(xc), .in_ctx(xcctx),
    .in_aux(xz), .out_vld(xv), .out_vec(x), .out_ctx(xctx), .out_aux(xzx));

  // up is spent once x exists: park z in its slots so it stays matched with y
  assign xzctx = {xctx.ex, xctx.ey, xctx.ez, xzx};

  // z rides in ctx; x travels alongside in aux
  lav_cross u_cy (.clk, .rst_n, .in_vld(xv), .in_a(xzx), .in_b(x),
    .in_ctx(xzctx), .in_aux(x), .out_vld(ycv), .out_vec(yc), .out_ctx(ycctx),
    .out_aux(yx));

  lav_norm u_ny (.clk, .rst_n, .in_vld(ycv), .in_vec(yc), .in_ctx(ycctx),
    .in_aux(yx), .out_vld(yv), .out_vec(y), .out_ctx(yctx), .out_aux(yz));

  assign zy = {yctx.ux, yctx.uy, yctx.uz};

  // translations; the products and their sum are registered
  lav_pkg::q_t tx, ty, tz;
  lav_trans u_tx (.clk, .in_axis(yz), .in_ctx(yctx), .out_t(tx));
  lav_trans u_ty (.clk, .in_axis(y), .in_ctx(yctx), .out_t(ty));
  lav_trans u_tz (.clk, .in_axis(zy), .in_ctx(yctx), .out_t(tz));

  lav_pkg::vec32_t xa_r [2], ya_r [2], za_r [2];
  logic [1:0] tv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 2'd0;
    end else begin
      tv_r <= {tv_r[0], yv};
    end
    xa_r[0] <= yz; xa_r[1] <= xa_r[0];
    ya_r[0] <= y;  ya_r[1] <= ya_r[0];
    za_r[0] <= zy; za_r[1] <= za_r[0];
  end

  // serializer: four rows; busy spaces items so one item's rows finish first
  logic [1:0]       row_r;
  logic             act_r;
  lav_pkg::vec32_t  rx_r, ry_r, rz_r;
  lav_pkg::q_t      rtx_r, rty_r, rtz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= 2'd0;
    end else if (tv_r[1]) begin
      act_r <= 1'b1;
      row_r <= 2'd0;
    end else if (act_r) begin
      row_r <= row_r + 2'd1;
      if (row_r == 2'd3) act_r <= 1'b0;
    end
    if (tv_r[1]) begin
      rx_r <= xa_r[1]; ry_r <= ya_r[1]; rz_r <= za_r[1];
      rtx_r <= tx; rty_r <= ty; rtz_r <= tz;
    end
  end

  always_comb begin
    out_valid = act_r;
    out_row_index = row_r;
    out_last_row = (row_r == 2'd3);
    unique case (row_r)
      2'd0: {out_col0, out_col1, out_col2, out_col3} = {rx_r, rtx_r};
      2'd1: {out_col0, out_col1, out_col2, out_col3} = {ry_r, rty_r};
      2'd2: {out_col0, out_col1, out_col2, out_col3} = {rz_r, rtz_r};
      default: begin
        out_col0 = '0; out_col1 = '0; out_col2 = '0;
        out_col3 = 32'(1) << lav_pkg::FRAC_BITS;
      end
    endcase
  end

endmodule

// ===== design/lav_checker.sv =====
module lav_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_row_index,
  input logic       out_last_row
);

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd3)))
    else $error("last_row mismatch");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_index != 2'd3) |=>
      (out_valid && out_row_index == $past(out_row_index) + 2'd1))
    else $error("row sequence broken");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (.clk, .rst_n, .start,
  .busy, .out_valid, .out_row_index, .out_last_row);

// ===== dv/tb_look_at_view_matrix_unit.sv =====
`timescale 1ns / 100ps

module tb_look_at_view_matrix_unit;

  localparam int LATENCY = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [31:0] eye_x, eye_y, eye_z;
    logic [31:0] tgt_x, tgt_y, tgt_z;
    logic [31:0] up_x, up_y, up_z;
  } camera_word_t;

  typedef struct {
    logic [1:0]  row_index;
    logic [31:0] col0, col1, col2, col3;
    logic        last_row;
  } row_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic [31:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic        out_valid;
  logic [1:0]  out_row_index;
  logic [31:0] out_col0, out_col1, out_col2, out_col3;
  logic        out_last_row;

  camera_word_t pending_cams[$];
  row_word_t    expected_rows[$];
  int  mismatches = 0;
  int  idle_pct = 31;
  bit  hold_until_drained = 1'b0;
  int  quiet_cycles = 0;

  look_at_view_matrix_unit uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v[3], output longint r[3]);
    logic [63:0] m[3];
    logic [63:0] mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << lav_pkg::FRAC_BITS) + (len >> 1)) / len;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Axes are at most 1.0, so the dot product stays below 2^49.
  function automatic logic [31:0] view_offset(input longint ax[3], input longint eye[3]);
    longint d;
    logic [63:0] m, q;
    d = -(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]);
    m = d < 0 ? -d : d;
    q = (m + (64'd1 << (lav_pkg::FRAC_BITS - 1))) >> lav_pkg::FRAC_BITS;
    if (d < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-longint'(q));
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic void predict_view_rows(input camera_word_t c);
    longint eye[3], up[3], d[3], zax[3], xax[3], yax[3], t[3];
    row_word_t row;
    eye[0] = longint'(signed'(c.eye_x));
    eye[1] = longint'(signed'(c.eye_y));
    eye[2] = longint'(signed'(c.eye_z));
    d[0] = eye[0] - longint'(signed'(c.tgt_x));
    d[1] = eye[1] - longint'(signed'(c.tgt_y));
    d[2] = eye[2] - longint'(signed'(c.tgt_z));
    up[0] = longint'(signed'(c.up_x));
    up[1] = longint'(signed'(c.up_y));
    up[2] = longint'(signed'(c.up_z));
    unit_vector(d, zax);
    cross_prod(up, zax, t);
    unit_vector(t, xax);
    cross_prod(zax, xax, t);
    unit_vector(t, yax);
    for (int r = 0; r < 4; r++) begin
      row.row_index = 2'(r);
      row.last_row = (r == 3);
      unique case (r)
        0: begin
          row.col0 = 32'(xax[0]); row.col1 = 32'(xax[1]); row.col2 = 32'(xax[2]);
          row.col3 = view_offset(xax, eye);
        end
        1: begin
          row.col0 = 32'(yax[0]); row.col1 = 32'(yax[1]); row.col2 = 32'(yax[2]);
          row.col3 = view_offset(yax, eye);
        end
        2: begin
          row.col0 = 32'(zax[0]); row.col1 = 32'(zax[1]); row.col2 = 32'(zax[2]);
          row.col3 = view_offset(zax, eye);
        end
        default: begin
          row.col0 = 0; row.col1 = 0; row.col2 = 0;
          row.col3 = 32'd1 << lav_pkg::FRAC_BITS;
        end
      endcase
      expected_rows.push_back(row);
    end
  endfunction

  function automatic camera_word_t make_cam(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                            ux, uy, uz);
    camera_word_t c;
    c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
    c.tgt_x = tx; c.tgt_y = ty; c.tgt_z = tz;
    c.up_x = ux; c.up_y = uy; c.up_z = uz;
    return c;
  endfunction

  function automatic logic [31:0] rand_coord();
    unique case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  // Driver: raise start for one word at a time, drop it once taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_view_rows(pending_cams.pop_front());
        start <= 1'b0;
      end else if (!start && pending_cams.size() > 0 && !hold_until_drained &&
                   $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_eye_x <= pending_cams[0].eye_x;
        in_eye_y <= pending_cams[0].eye_y;
        in_eye_z <= pending_cams[0].eye_z;
        in_target_x <= pending_cams[0].tgt_x;
        in_target_y <= pending_cams[0].tgt_y;
        in_target_z <= pending_cams[0].tgt_z;
        in_up_x <= pending_cams[0].up_x;
        in_up_y <= pending_cams[0].up_y;
        in_up_z <= pending_cams[0].up_z;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    row_word_t want;
    if (rst_n) begin
      quiet_cycles <= (out_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
      if (out_valid) begin
        if (expected_rows.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected row word %0d", out_row_index);
        end else begin
          want = expected_rows.pop_front();
          if (out_row_index !== want.row_index || out_col0 !== want.col0 ||
              out_col1 !== want.col1 || out_col2 !== want.col2 ||
              out_col3 !== want.col3 || out_last_row !== want.last_row) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("row mismatch exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
                       want.row_index, want.col0, want.col1, want.col2, want.col3,
                       want.last_row, out_row_index, out_col0, out_col1, out_col2,
                       out_col3, out_last_row);
          end
        end
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("tb_look_at_view_matrix_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] one;
    one = 32'd1 << lav_pkg::FRAC_BITS;
    pending_cams.push_back(make_cam(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
    // eye on target
    pending_cams.push_back(make_cam(one, 2 * one, 3 * one, one, 2 * one, 3 * one,
                                    0, one, 0));
    // up parallel to view direction
    pending_cams.push_back(make_cam(0, 0, one, 0, 0, 0, 0, 0, 7 * one));
    // zero up vector
    pending_cams.push_back(make_cam(one, one, one, 0, 0, 0, 0, 0, 0));
    pending_cams.push_back(make_cam(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_cams.push_back(make_cam(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_cams.push_back(make_cam(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFE, 0, 0,
                                    0, 32'h7FFF_FFFF, 0));
    pending_cams.push_back(make_cam(1, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_cams.push_back(make_cam(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    0, 0, 0, 1, 0, 0));
    pending_cams.push_back(make_cam(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    0, one, 0));
    pending_cams.push_back(make_cam(3 * one, 4 * one, 0, 0, 0, 0, 0, 0, one));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cams.size() == 0);
    // let every row of the directed words come back before going on
    hold_until_drained = 1'b1;
    wait (expected_rows.size() == 0 && !start);
    hold_until_drained = 1'b0;
    for (int n = 0; n < 99; n++) begin
      pending_cams.push_back(make_cam(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord()));
    end
    wait (pending_cams.size() <= 65);
    idle_pct = 0;
    wait (pending_cams.size() <= 35);
    idle_pct = 31;
    wait (pending_cams.size() == 0 && !start);
    wait (expected_rows.size() == 0);
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("tb_look_at_view_matrix_unit: clean");
    end else begin
      $display("tb_look_at_view_matrix_unit: errors");
    end
    $finish;
  end

endmodule

// ===== look_at_view_matrix_unit.f =====
design/lav_pkg.sv
design/lav_norm.sv
design/lav_cross.sv
design/lav_trans.sv
design/look_at_view_matrix_unit.sv
design/lav_checker.sv
dv/tb_look_at_view_matrix_unit.sv
